>>> rtl/sha256_message_digest_macros.svh
// ----------------------------------------------------------------------------
// SHA-256 digest assertion macros
// Concurrent check wrappers clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SHA256_MESSAGE_DIGEST_MACROS_SVH
`define SHA256_MESSAGE_DIGEST_MACROS_SVH

// same-cycle implication
`define SHA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SHA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/sha256_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 digest package
// Transaction types, round constants, initial hash values and sigma functions.
// ----------------------------------------------------------------------------
package sha256_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic        word_last;
    } t_out_item;

    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam logic [5:0] LEN_POS    = 6'd56;
    localparam logic [5:0] LAST_POS   = 6'd63;
    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [2:0] LAST_WORD  = 3'd7;

    localparam logic [31:0] HASH_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

>>> rtl/sha256_message_digest.sv
// ----------------------------------------------------------------------------
// SHA-256 message digest
// Data byte: one per cycle while idle; a block's 64th byte adds 64 rounds + add.
// Last transaction: a setup state, one pad byte per cycle, 64 rounds + add per
// padded block, then eight digest words, one per cycle while i_ready is high.
// One round unit is shared over all 64 rounds of every block.
// Synchronous active-low reset: idle, initial hash values, length zero.
// ----------------------------------------------------------------------------
`include "sha256_message_digest_macros.svh"

module sha256_message_digest (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  sha256_pkg::t_in_item  i_data,
    output logic                  o_valid,
    input  logic                  i_ready,
    output sha256_pkg::t_out_item o_data
);
    import sha256_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_FINISH,
        ST_PAD,
        ST_OUT
    } t_state;

    t_state      r_state;
    logic [31:0] r_w [16];
    logic [31:0] r_v [8];
    logic [31:0] r_h [8];
    logic [5:0]  r_round;
    logic [2:0]  r_oidx;
    logic [5:0]  r_pos;
    logic [60:0] r_count;
    logic [63:0] r_len;
    logic        r_fin;
    logic        r_padding;
    logic        r_mark;
    logic        r_two;
    logic        r_final;

    logic        in_fire;
    logic        out_fire;
    logic [31:0] w_t1;
    logic [31:0] w_t2;
    logic [31:0] w_sched;
    logic        w_len_sel;
    logic [7:0]  w_pad_byte;
    logic        w_pad_two;

    assign in_fire  = i_valid && o_ready;
    assign out_fire = o_valid && i_ready;

    assign o_ready            = (r_state == ST_IDLE);
    assign o_valid            = (r_state == ST_OUT);
    assign o_data.digest_word = r_h[0];
    assign o_data.word_last   = (r_oidx == LAST_WORD);

    always_comb begin
        w_t1 = r_v[7] + big_sigma1(r_v[4])
             + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
             + ROUND_K[r_round] + r_w[0];
        w_t2 = big_sigma0(r_v[0])
             + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
        w_sched = small_sigma1(r_w[14]) + r_w[9] + small_sigma0(r_w[1]) + r_w[0];
        w_len_sel = !r_mark && !r_two && (r_pos >= LEN_POS);
        if (r_mark) begin
            w_pad_byte = PAD_MARK;
        end else if (w_len_sel) begin
            w_pad_byte = r_len[63:56];
        end else begin
            w_pad_byte = 8'h00;
        end
        // marker landing in the length field forces a second block
        w_pad_two = r_mark ? (r_pos >= LEN_POS) : r_two;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_round   <= '0;
            r_oidx    <= '0;
            r_pos     <= '0;
            r_count   <= '0;
            r_fin     <= 1'b0;
            r_padding <= 1'b0;
            r_mark    <= 1'b0;
            r_two     <= 1'b0;
            r_final   <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= HASH_INIT[i];
            end
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        if (i_data.byte_valid) begin
                            for (int i = 0; i < 15; i++) begin
                                r_w[i] <= {r_w[i][23:0], r_w[i+1][31:24]};
                            end
                            r_w[15]   <= {r_w[15][23:0], i_data.data_byte};
                            r_pos     <= r_pos + 6'd1;
                            r_count   <= r_count + 61'd1;
                            if (r_pos == LAST_POS) begin
                                r_state   <= ST_ROUND;
                                r_round   <= '0;
                                r_fin     <= i_data.last;
                                r_padding <= 1'b0;
                                for (int i = 0; i < 8; i++) begin
                                    r_v[i] <= r_h[i];
                                end
                            end else if (i_data.last) begin
                                r_state <= ST_FINISH;
                            end
                        end else if (i_data.last) begin
                            r_state <= ST_FINISH;
                        end
                    end
                end
                ST_FINISH: begin
                    r_len     <= {r_count, 3'b000};
                    r_mark    <= 1'b1;
                    r_two     <= 1'b0;
                    r_padding <= 1'b1;
                    r_state   <= ST_PAD;
                end
                ST_PAD: begin
                    for (int i = 0; i < 15; i++) begin
                        r_w[i] <= {r_w[i][23:0], r_w[i+1][31:24]};
                    end
                    r_w[15] <= {r_w[15][23:0], w_pad_byte};
                    r_pos   <= r_pos + 6'd1;
                    r_mark  <= 1'b0;
                    r_two   <= (r_pos == LAST_POS) ? 1'b0 : w_pad_two;
                    if (w_len_sel) begin
                        r_len <= {r_len[55:0], 8'h00};
                    end
                    if (r_pos == LAST_POS) begin
                        r_final <= !w_pad_two;
                        r_state <= ST_ROUND;
                        r_round <= '0;
                        for (int i = 0; i < 8; i++) begin
                            r_v[i] <= r_h[i];
                        end
                    end
                end
                ST_ROUND: begin
                    r_v[0] <= w_t1 + w_t2;
                    r_v[1] <= r_v[0];
                    r_v[2] <= r_v[1];
                    r_v[3] <= r_v[2];
                    r_v[4] <= r_v[3] + w_t1;
                    r_v[5] <= r_v[4];
                    r_v[6] <= r_v[5];
                    r_v[7] <= r_v[6];
                    for (int i = 0; i < 15; i++) begin
                        r_w[i] <= r_w[i+1];
                    end
                    r_w[15] <= w_sched;
                    r_round <= r_round + 6'd1;
                    if (r_round == LAST_ROUND) begin
                        r_state <= ST_ADD;
                    end
                end
                ST_ADD: begin
                    for (int i = 0; i < 8; i++) begin
                        r_h[i] <= r_h[i] + r_v[i];
                    end
                    r_oidx <= '0;
                    if (!r_padding) begin
                        r_state <= r_fin ? ST_FINISH : ST_IDLE;
                    end else begin
                        r_state <= r_final ? ST_OUT : ST_PAD;
                    end
                end
                ST_OUT: begin
                    if (out_fire) begin
                        // shift the digest out, refill with the initial values
                        for (int i = 0; i < 7; i++) begin
                            r_h[i] <= r_h[i+1];
                        end
                        r_h[7] <= HASH_INIT[r_oidx];
                        r_oidx <= r_oidx + 3'd1;
                        if (r_oidx == LAST_WORD) begin
                            r_state   <= ST_IDLE;
                            r_count   <= '0;
                            r_pos     <= '0;
                            r_padding <= 1'b0;
                            r_fin     <= 1'b0;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    `SHA_ASSERT_IMP(a_no_overlap, o_valid, !o_ready, "accepting input while emitting digest")
    `SHA_ASSERT_NXT(a_round_step, (r_state == ST_ROUND) && (r_round != LAST_ROUND),
        (r_state == ST_ROUND) && (r_round == $past(r_round) + 6'd1), "round counter skipped")
    `SHA_ASSERT_NXT(a_msg_done, out_fire && o_data.word_last,
        o_ready && (r_count == '0), "message state not cleared after digest")
    `SHA_ASSERT_IMP(a_pos_sync, r_state == ST_IDLE, r_pos == r_count[5:0],
        "block position out of step with byte count")

endmodule

>>> tb/sha256_message_digest_tb.sv
// ----------------------------------------------------------------------------
// SHA-256 message digest testbench
// Streams byte transactions into the digest block and checks every digest
// word against an in-bench SHA-256 model. Covers the empty message, byte and
// last together, ignored transactions, byte extremes and random messages
// across block and padding boundaries, with random sender gaps and receiver
// stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha256_message_digest_tb;

    import sha256_pkg::*;

    localparam int          CLK_PERIOD   = 12;
    localparam int          ITEM_TARGET  = 280;
    localparam int          STUCK_LIMIT  = 2000;
    localparam int          DRAIN_CYCLES = 300;
    localparam logic [7:0]  PAD_BYTE     = 8'h80;
    localparam logic [5:0]  LEN_OFFSET   = 6'd56;
    localparam logic [5:0]  BLOCK_END    = 6'd63;
    localparam int          DIGEST_WORDS = 8;

    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] KTAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_ready;
    t_in_item  i_data  = '0;
    logic      o_valid;
    logic      i_ready = 1'b0;
    t_out_item o_data;

    logic [31:0] chain_h [8];
    logic [7:0]  chunk_buf [64];
    logic [60:0] msg_bytes;

    t_out_item   expected_words [$];
    t_out_item   want;
    int          mismatch_count = 0;
    int          stim_count     = 0;
    int          burst_left     = 0;
    int          stuck_cycles   = 0;
    logic [15:0] ready_mask     = 16'hffff;
    logic [3:0]  ready_phase    = '0;

    sha256_message_digest uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void restart_digest();
        for (int i = 0; i < 8; i++) chain_h[i] = IV[i];
        for (int i = 0; i < 64; i++) chunk_buf[i] = 8'h00;
        msg_bytes = '0;
    endfunction

    function automatic void compress_chunk();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] s0, s1, t1, t2;
        for (int r = 0; r < 16; r++) begin
            w[r] = {chunk_buf[4*r], chunk_buf[4*r+1], chunk_buf[4*r+2], chunk_buf[4*r+3]};
        end
        for (int r = 16; r < 64; r++) begin
            s0 = rotr(w[r-15], 7) ^ rotr(w[r-15], 18) ^ (w[r-15] >> 3);
            s1 = rotr(w[r-2], 17) ^ rotr(w[r-2], 19) ^ (w[r-2] >> 10);
            w[r] = w[r-16] + s0 + w[r-7] + s1;
        end
        for (int i = 0; i < 8; i++) v[i] = chain_h[i];
        for (int r = 0; r < 64; r++) begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTAB[r] + w[r];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) chain_h[i] = chain_h[i] + v[i];
    endfunction

    function automatic void pad_and_close();
        logic [5:0]  pos;
        logic [63:0] bit_len;
        pos     = msg_bytes[5:0];
        bit_len = {msg_bytes, 3'b000};
        chunk_buf[pos] = PAD_BYTE;
        for (int i = int'(pos) + 1; i < 64; i++) chunk_buf[i] = 8'h00;
        if (pos >= LEN_OFFSET) begin
            compress_chunk();
            for (int i = 0; i < 64; i++) chunk_buf[i] = 8'h00;
        end
        for (int i = 0; i < 8; i++) chunk_buf[int'(LEN_OFFSET) + i] = bit_len[63 - 8*i -: 8];
        compress_chunk();
    endfunction

    function automatic void absorb_item(input t_in_item item);
        logic [5:0] pos;
        t_out_item  word;
        if (item.byte_valid) begin
            pos = msg_bytes[5:0];
            chunk_buf[pos] = item.data_byte;
            msg_bytes = msg_bytes + 1'b1;
            if (pos == BLOCK_END) compress_chunk();
        end
        if (item.last) begin
            pad_and_close();
            for (int i = 0; i < DIGEST_WORDS; i++) begin
                word.digest_word = chain_h[i];
                word.word_last   = (i == DIGEST_WORDS - 1);
                expected_words = {expected_words, word};
            end
            restart_digest();
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        $display("mismatch: %s got %h expected %h", what, got, exp_val);
        mismatch_count++;
    endtask

    task automatic send_item(input logic [7:0] b, input logic bv, input logic lst);
        t_in_item item;
        int       gap;
        item.data_byte  = b;
        item.byte_valid = bv;
        item.last       = lst;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 12);
        end
        i_valid <= 1'b1;
        i_data  <= item;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        burst_left--;
        absorb_item(item);
        stim_count++;
    endtask

    task automatic test_empty_message();
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hff, 1'b0, 1'b1);
    endtask

    task automatic test_byte_with_last();
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
    endtask

    task automatic test_ignored_and_extremes();
        send_item(8'hff, 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'h5a, 1'b0, 1'b0);
        send_item(8'hff, 1'b1, 1'b0);
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'h7f, 1'b1, 1'b0);
        send_item(8'ha5, 1'b0, 1'b1);
    endtask

    task automatic test_random_messages();
        int   pick;
        int   len;
        logic close_on_byte;
        while (stim_count < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 3)       len = $urandom_range(119, 129);
            else if (pick < 20) len = $urandom_range(55, 65);
            else                len = $urandom_range(0, 20);
            close_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(0, 7) == 0) send_item(8'($urandom), 1'b0, 1'b0);
                send_item(8'($urandom), 1'b1, close_on_byte && (k == len - 1));
            end
            if (!close_on_byte) send_item(8'($urandom), 1'b0, 1'b1);
        end
    endtask

    // receiver stall pattern, bit 0 always set so stalls stay bounded
    always @(posedge i_clk) begin
        if (ready_phase == 4'd0) begin
            ready_mask = ($urandom_range(0, 3) == 0) ? 16'hffff : (16'($urandom) | 16'h0001);
        end
        i_ready <= ready_mask[ready_phase];
        ready_phase = ready_phase + 1'b1;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_words.size() == 0) begin
                report_mismatch("unexpected digest word", o_data.digest_word, 32'h0);
            end else begin
                want = expected_words.pop_front();
                if (o_data.digest_word !== want.digest_word)
                    report_mismatch("digest_word", o_data.digest_word, want.digest_word);
                if (o_data.word_last !== want.word_last)
                    report_mismatch("word_last", 32'(o_data.word_last), 32'(want.word_last));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) stuck_cycles <= 0;
        else stuck_cycles <= stuck_cycles + 1;
    end

    initial begin
        while (stuck_cycles < STUCK_LIMIT) @(posedge i_clk);
        $display("[sha256_message_digest] ERROR");
        $finish;
    end

    initial begin
        restart_digest();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_message();
        test_byte_with_last();
        test_ignored_and_extremes();
        test_random_messages();
        i_valid <= 1'b0;
        while (expected_words.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_words.size() == 0) begin
            $display("[sha256_message_digest] OK");
        end else begin
            $display("[sha256_message_digest] ERROR");
        end
        $finish;
    end

endmodule
